@@ design/rsdt_pkg.sv @@
// ----------------------------------------------------------------------------
// rsdt_pkg
// Shared types and constants for the spike distance term datapath.
// ----------------------------------------------------------------------------
package rsdt_pkg;

    localparam int TIME_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    // L and R in half-LSB units
    localparam int X_W         = TIME_WIDTH + 2;
    localparam int NUM_W       = TIME_WIDTH + 1;
    localparam int E_W         = $clog2(X_W);
    localparam int LOG_FRAC    = 32;
    localparam int LOG_LAT     = LOG_FRAC + 1;
    localparam int LOG_OFFSET  = FRAC_BITS + 1;
    localparam int POST_SHIFT  = 34 - FRAC_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EQUAL    = 2'd1,
        ST_NEG_ARG  = 2'd2,
        ST_ZERO_LEN = 2'd3
    } status_t;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] spike_time_a;
        logic [TIME_WIDTH-1:0] spike_time_b;
        logic [TIME_WIDTH-1:0] neighbor_dist_a;
        logic [TIME_WIDTH-1:0] neighbor_dist_b;
        logic [TIME_WIDTH-1:0] interval_end;
        logic [TIME_WIDTH-1:0] interval_length;
    } in_t;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] distance_term;
        status_t               status;
    } out_t;

    // classified request handed from front to back
    typedef struct packed {
        status_t               status;
        logic [X_W-1:0]        l2;
        logic [X_W-1:0]        r2;
        logic [NUM_W-1:0]      num;
        logic [TIME_WIDTH-1:0] len;
    } work_t;

endpackage

@@ design/rsdt_front.sv @@
// ----------------------------------------------------------------------------
// rsdt_front
// Classify a request: special cases, log arguments and the numerator.
// ----------------------------------------------------------------------------
module rsdt_front import rsdt_pkg::*; (
    input  in_t   req,
    output work_t work
);

    logic signed [X_W+1:0] l2_s;
    logic signed [X_W+1:0] r2_s;
    logic                  a_early;

    always_comb begin
        l2_s = $signed({3'b000, req.interval_end, 1'b0})
             - $signed({4'b0000, req.spike_time_a})
             - $signed({4'b0000, req.spike_time_b});
        r2_s = l2_s - $signed({3'b000, req.interval_length, 1'b0});
        a_early = req.spike_time_a < req.spike_time_b;

        if (req.spike_time_a == req.spike_time_b) begin
            work.status = ST_EQUAL;
        end else if (req.interval_length == '0) begin
            work.status = ST_ZERO_LEN;
        end else if (l2_s[X_W+1] || r2_s[X_W+1]) begin
            work.status = ST_NEG_ARG;
        end else begin
            work.status = ST_OK;
        end

        work.l2  = l2_s[X_W-1:0];
        work.r2  = r2_s[X_W-1:0];
        work.len = req.interval_length;
        if (a_early) begin
            work.num = NUM_W'(req.spike_time_b) - NUM_W'(req.spike_time_a)
                     + NUM_W'(req.neighbor_dist_a);
        end else begin
            work.num = NUM_W'(req.spike_time_a) - NUM_W'(req.spike_time_b)
                     + NUM_W'(req.neighbor_dist_b);
        end
    end

endmodule

@@ design/rsdt_queue.sv @@
// ----------------------------------------------------------------------------
// rsdt_queue
// Short FIFO that decouples the front from the back pipeline.
// ----------------------------------------------------------------------------
module rsdt_queue import rsdt_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  work_t push_item,
    output logic  full,
    output logic  q_valid,
    output work_t q_item,
    input  logic  pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    work_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign full    = cnt_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign q_valid = cnt_reg != '0;
    assign q_item  = mem[rd_ptr_reg];

endmodule

@@ design/rsdt_log2.sv @@
// ----------------------------------------------------------------------------
// rsdt_log2
// Pipelined log2: normalize, then one squaring per fraction bit.
// ----------------------------------------------------------------------------
module rsdt_log2 import rsdt_pkg::*; (
    input  logic                aclk,
    input  logic                en,
    input  logic [X_W-1:0]      x,
    output logic [E_W-1:0]      exp_out,
    output logic [LOG_FRAC-1:0] frac_out
);

    logic [31:0]         m_reg [LOG_FRAC+1];
    logic [E_W-1:0]      e_reg [LOG_FRAC+1];
    logic [LOG_FRAC-1:0] f_reg [LOG_FRAC+1];
    logic [31:0]         m_next [LOG_FRAC+1];
    logic [LOG_FRAC-1:0] f_next [LOG_FRAC+1];
    logic [63:0]         sq [LOG_FRAC+1];
    logic [32:0]         t [LOG_FRAC+1];
    logic [E_W-1:0]      msb;
    logic [X_W+30:0]     wide;

    always_comb begin
        msb = '0;
        for (int i = 0; i < X_W; i++) begin
            if (x[i]) begin
                msb = E_W'(i);
            end
        end
        wide = {x, 31'b0} >> msb;
        m_next[0] = wide[31:0];
        f_next[0] = '0;
        sq[0] = '0;
        t[0]  = '0;
        for (int k = 1; k <= LOG_FRAC; k++) begin
            sq[k] = 64'(m_reg[k-1]) * 64'(m_reg[k-1]);
            t[k]  = sq[k][63:31];
            f_next[k] = f_reg[k-1];
            if (t[k][32]) begin
                m_next[k] = t[k][32:1];
                f_next[k][LOG_FRAC-k] = 1'b1;
            end else begin
                m_next[k] = t[k][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0] <= m_next[0];
            e_reg[0] <= msb;
            f_reg[0] <= f_next[0];
            for (int k = 1; k <= LOG_FRAC; k++) begin
                m_reg[k] <= m_next[k];
                e_reg[k] <= e_reg[k-1];
                f_reg[k] <= f_next[k];
            end
        end
    end

    assign exp_out  = e_reg[LOG_FRAC];
    assign frac_out = f_reg[LOG_FRAC];

endmodule

@@ design/rsdt_back.sv @@
// ----------------------------------------------------------------------------
// rsdt_back
// Back pipeline: logs, ln scaling, product and restoring division.
// ----------------------------------------------------------------------------
module rsdt_back import rsdt_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  q_valid,
    input  work_t q_item,
    output logic  q_pop,
    output logic  m_valid,
    input  logic  m_ready,
    output out_t  m_data
);

    localparam int LOGV_W = E_W + 2 + LOG_FRAC;
    localparam int DLOG_W = LOGV_W + 1;
    localparam int PI_W   = E_W + 32;
    localparam int DLN_W  = PI_W + 1;
    localparam int PL_W   = NUM_W + 32;
    localparam int PH_W   = NUM_W + DLN_W - 32;
    localparam int P_W    = NUM_W + DLN_W;
    localparam int LO_POS = POST_SHIFT + TIME_WIDTH;
    localparam int HI_W   = P_W - LO_POS;
    localparam int NSTG   = LOG_LAT + 6 + TIME_WIDTH;

    typedef struct packed {
        status_t               status;
        logic                  lz;
        logic                  rz;
        logic [NUM_W-1:0]      num;
        logic [TIME_WIDTH-1:0] len;
    } side_t;

    logic                  adv;
    logic [NSTG-1:0]       vld_reg;
    logic                  m_valid_reg;
    out_t                  m_data_reg;
    side_t                 side_reg [LOG_LAT];

    logic [E_W-1:0]        el, er;
    logic [LOG_FRAC-1:0]   fl, fr;
    logic signed [E_W+1:0] il, ir;
    logic signed [LOGV_W-1:0] lvl, lvr;
    logic signed [DLOG_W-1:0] dlog;

    status_t               s1_status;
    logic [NUM_W-1:0]      s1_num;
    logic [TIME_WIDTH-1:0] s1_len;
    logic signed [DLOG_W-1:0] s1_dlog;

    status_t               s2_status, s3_status, s4_status, s5_status;
    logic                  s2_zero, s3_zero, s4_zero, s5_zero;
    logic [NUM_W-1:0]      s2_num, s3_num;
    logic [TIME_WIDTH-1:0] s2_len, s3_len, s4_len, s5_len;
    logic [PI_W-1:0]       s2_pi;
    logic [63:0]           s2_pf;
    logic [DLN_W-1:0]      s3_dln;
    logic [PL_W-1:0]       s4_pl;
    logic [PH_W-1:0]       s4_ph;
    logic [P_W-1:0]        s5_p;

    logic [HI_W-1:0]       hi;
    logic                  over;

    logic [TIME_WIDTH-1:0] d_rem  [TIME_WIDTH+1];
    logic [TIME_WIDTH-1:0] d_dq   [TIME_WIDTH+1];
    logic [TIME_WIDTH-1:0] d_len  [TIME_WIDTH+1];
    logic                  d_zero [TIME_WIDTH+1];
    logic                  d_over [TIME_WIDTH+1];
    status_t               d_stat [TIME_WIDTH+1];
    logic [TIME_WIDTH:0]   dt     [TIME_WIDTH+1];
    logic                  dge    [TIME_WIDTH+1];

    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && q_valid;

    rsdt_log2 u_log_l (
        .aclk     (aclk),
        .en       (adv),
        .x        (q_item.l2),
        .exp_out  (el),
        .frac_out (fl)
    );

    rsdt_log2 u_log_r (
        .aclk     (aclk),
        .en       (adv),
        .x        (q_item.r2),
        .exp_out  (er),
        .frac_out (fr)
    );

    // log values, zero argument counts as zero
    always_comb begin
        il  = $signed({2'b00, el}) - $signed((E_W+2)'(LOG_OFFSET));
        ir  = $signed({2'b00, er}) - $signed((E_W+2)'(LOG_OFFSET));
        lvl = side_reg[LOG_LAT-1].lz ? '0 : {il, fl};
        lvr = side_reg[LOG_LAT-1].rz ? '0 : {ir, fr};
        dlog = DLOG_W'(lvl) - DLOG_W'(lvr);
        hi   = s5_p[P_W-1:LO_POS];
        over = (HI_W+TIME_WIDTH)'(hi) >= (HI_W+TIME_WIDTH)'(s5_len);
        dt[0]  = '0;
        dge[0] = 1'b0;
        for (int k = 1; k <= TIME_WIDTH; k++) begin
            dt[k]  = {d_rem[k-1], d_dq[k-1][TIME_WIDTH-1]};
            dge[k] = dt[k] >= {1'b0, d_len[k-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[NSTG-2:0], q_valid};
            m_valid_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= '{status: q_item.status, lz: q_item.l2 == '0,
                             rz: q_item.r2 == '0, num: q_item.num, len: q_item.len};
            for (int k = 1; k < LOG_LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end

            s1_status <= side_reg[LOG_LAT-1].status;
            s1_num    <= side_reg[LOG_LAT-1].num;
            s1_len    <= side_reg[LOG_LAT-1].len;
            s1_dlog   <= dlog;

            s2_status <= s1_status;
            s2_zero   <= (s1_status != ST_OK) || s1_dlog[DLOG_W-1] || (s1_dlog == '0);
            s2_num    <= s1_num;
            s2_len    <= s1_len;
            s2_pi     <= PI_W'(s1_dlog[LOG_FRAC+E_W-1:LOG_FRAC]) * PI_W'(LN2_Q32);
            s2_pf     <= 64'(s1_dlog[LOG_FRAC-1:0]) * 64'(LN2_Q32);

            s3_status <= s2_status;
            s3_zero   <= s2_zero;
            s3_num    <= s2_num;
            s3_len    <= s2_len;
            s3_dln    <= DLN_W'(s2_pi) + DLN_W'(s2_pf[63:32]);

            s4_status <= s3_status;
            s4_zero   <= s3_zero;
            s4_len    <= s3_len;
            s4_pl     <= PL_W'(s3_num) * PL_W'(s3_dln[31:0]);
            s4_ph     <= PH_W'(s3_num) * PH_W'(s3_dln[DLN_W-1:32]);

            s5_status <= s4_status;
            s5_zero   <= s4_zero;
            s5_len    <= s4_len;
            s5_p      <= P_W'(s4_pl) + (P_W'(s4_ph) << 32);

            d_stat[0] <= s5_status;
            d_zero[0] <= s5_zero;
            d_over[0] <= over;
            d_len[0]  <= s5_len;
            d_rem[0]  <= over ? '0 : TIME_WIDTH'(hi);
            d_dq[0]   <= s5_p[LO_POS-1:POST_SHIFT];

            for (int k = 1; k <= TIME_WIDTH; k++) begin
                d_stat[k] <= d_stat[k-1];
                d_zero[k] <= d_zero[k-1];
                d_over[k] <= d_over[k-1];
                d_len[k]  <= d_len[k-1];
                d_rem[k]  <= dge[k] ? TIME_WIDTH'(dt[k] - {1'b0, d_len[k-1]})
                                    : dt[k][TIME_WIDTH-1:0];
                d_dq[k]   <= {d_dq[k-1][TIME_WIDTH-2:0], dge[k]};
            end

            m_data_reg.status <= d_stat[TIME_WIDTH];
            if (d_zero[TIME_WIDTH]) begin
                m_data_reg.distance_term <= '0;
            end else if (d_over[TIME_WIDTH]) begin
                m_data_reg.distance_term <= '1;
            end else begin
                m_data_reg.distance_term <= d_dq[TIME_WIDTH];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ design/realtime_spike_distance_term.sv @@
// ----------------------------------------------------------------------------
// realtime_spike_distance_term
// Piecewise-constant spike distance term for one train pair and interval.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_data (in_t, six Q16.16 fields)
//  m_      | out       | m_valid / m_ready  | m_data (out_t, term and status)
//
//  Throughput is one request per cycle while m_ready does not stall the
//  back pipeline; from accept to m_valid a request passes the two 32-step
//  squaring log2 pipelines and the 32-step restoring divider in that pipeline.
//  Reset (aresetn low, synchronous) empties the queue and the pipeline.
//  A stall on m_ready freezes the back pipeline; the front keeps taking
//  requests until the queue fills, then drops s_ready.
// ----------------------------------------------------------------------------
module realtime_spike_distance_term import rsdt_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    work_t work;
    work_t q_item;
    logic  push;
    logic  full;
    logic  q_valid;
    logic  q_pop;

    // classify the incoming request
    rsdt_front u_front (
        .req  (s_data),
        .work (work)
    );

    // accept whenever the queue has room
    assign s_ready = !full;
    assign push    = s_valid && s_ready;

    // hold classified requests until the back pipeline advances
    rsdt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (work),
        .full      (full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop)
    );

    // compute logs, scale, multiply and divide; stall as one on m_ready
    rsdt_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ design/rsdt_checker.sv @@
// ----------------------------------------------------------------------------
// rsdt_checker
// Port-level checks on the spike distance term block.
// ----------------------------------------------------------------------------
module rsdt_checker import rsdt_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("request withdrawn while stalled");

    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK) |-> m_data.distance_term == '0)
        else $error("flagged result with nonzero term");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind realtime_spike_distance_term rsdt_checker u_rsdt_checker (.*);
